/* rtl/core/paa_pkg.sv */
// Package for the projectile aim angle pipeline: fixed-point constants,
// stage counts and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package paa_pkg;

	// elevation clamp, radians Q16
	localparam logic signed [17:0] ELEV_LIMIT = 18'sd102000;
	// gravity, Q16
	localparam logic [19:0] G_Q16 = 20'd642712;
	// rotation CORDIC start value, Q30
	localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
	// 90/pi in Q24
	localparam logic [29:0] DEG_PER_2RAD_Q24 = 30'd480631835;
	// unity in Q30 at the width of the argument check
	localparam logic signed [41:0] ONE_Q30 = 42'sd1073741824;
	// 2^60, radicand base for the asin cosine leg
	localparam logic [61:0] ONE_Q60 = 62'd1152921504606846976;
	// output clamp, degrees Q16
	localparam logic signed [63:0] OUT_MAX = 64'sd5898240;
	// rounding half for the Q16 result of the Q54 product
	localparam logic signed [63:0] ROUND_HALF = 64'sd137438953472;

	// stage counts
	localparam int DIV_STEPS    = 38;
	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS   = 31;

	// arctangent of 2^-i, truncated Q30
	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'h3243F6A8;
			5'd1:    v = 30'h1DAC6705;
			5'd2:    v = 30'h0FADBAFC;
			5'd3:    v = 30'h07F56EA6;
			5'd4:    v = 30'h03FEAB76;
			5'd5:    v = 30'h01FFD55B;
			5'd6:    v = 30'h00FFFAAA;
			5'd7:    v = 30'h007FFF55;
			5'd8:    v = 30'h003FFFEA;
			5'd9:    v = 30'h001FFFFD;
			5'd10:   v = 30'h000FFFFF;
			5'd11:   v = 30'h0007FFFF;
			5'd12:   v = 30'h0003FFFF;
			5'd13:   v = 30'h0001FFFF;
			5'd14:   v = 30'h0000FFFF;
			5'd15:   v = 30'h00007FFF;
			5'd16:   v = 30'h00003FFF;
			5'd17:   v = 30'h00001FFF;
			5'd18:   v = 30'h00000FFF;
			5'd19:   v = 30'h000007FF;
			5'd20:   v = 30'h000003FF;
			5'd21:   v = 30'h000001FF;
			5'd22:   v = 30'h000000FF;
			5'd23:   v = 30'h0000007F;
			5'd24:   v = 30'h0000003F;
			5'd25:   v = 30'h0000001F;
			5'd26:   v = 30'h0000000F;
			5'd27:   v = 30'h00000008;
			5'd28:   v = 30'h00000004;
			5'd29:   v = 30'h00000002;
			default: v = 30'h00000000;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/projectile_aim_angle.sv */
// Top level of the projectile aim angle pipeline: divider, sin/cos CORDIC,
// square root, vectoring CORDIC and degree conversion.
// Depends on paa_pkg.
//
// Use: drive range_dist, muzzle_speed and sight_elevation and pulse start.
// A beat is taken at every clock edge with start high and busy low; busy is
// always low, so one beat may enter in every cycle.
// Each beat gives one result beat: done is high for one cycle with
// aim_degrees (Q16 degrees) and unreachable on the ports.
// The pipeline is a chain of one-step stages: 38 restoring divider
// steps (with the 30 sin/cos CORDIC steps alongside), 31 square root steps
// and 30 vectoring CORDIC steps, plus the multiply and rounding stages.
// Zero range, zero speed, an oversized quotient or an arcsine argument
// beyond one give unreachable = 1 and aim_degrees = 0.
// Reset clears every valid bit, so no result beat appears until a new beat
// has gone through. The receiver cannot hold results off; the pipeline
// never stalls.
`default_nettype none

module projectile_aim_angle (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [23:0]        range_dist,
	input  wire logic [19:0]        muzzle_speed,
	input  wire logic signed [17:0] sight_elevation,
	output logic                    done,
	output logic signed [23:0]      aim_degrees,
	output logic                    unreachable
);

	localparam int ND = paa_pkg::DIV_STEPS;
	localparam int NC = paa_pkg::CORDIC_STEPS;
	localparam int NS = paa_pkg::SQRT_STEPS;

	// stage 1: clamp, zero check, products
	logic                vld_s1;
	logic                zero_s1;
	logic signed [17:0]  t_s1;
	logic [43:0]         p_s1;
	logic [39:0]         dd_s1;

	// divider and sin/cos stages
	logic                dv_vld_s  [0:ND];
	logic                dv_kill_s [0:ND];
	logic signed [17:0]  dv_t_s    [0:ND];
	logic [56:0]         dv_rem_s  [0:ND];
	logic [55:0]         dv_den_s  [0:ND];
	logic [37:0]         dv_quo_s  [0:ND];
	logic signed [32:0]  cs_x_s    [0:ND];
	logic signed [32:0]  cs_y_s    [0:ND];
	logic signed [32:0]  cs_z_s    [0:ND];

	logic [56:0]         dv_rem_n  [0:ND-1];
	logic [37:0]         dv_quo_n  [0:ND-1];
	logic signed [32:0]  cs_x_n    [0:ND-1];
	logic signed [32:0]  cs_y_n    [0:ND-1];
	logic signed [32:0]  cs_z_n    [0:ND-1];

	// product and argument stages
	logic                vld_s3, kill_s3, vld_s4, kill_s4, vld_s5, kill_s5;
	logic signed [17:0]  t_s3, t_s4, t_s5;
	logic [38:0]         prod_hi_s3;
	logic [60:0]         prod_lo_s3;
	logic signed [32:0]  sin_s3;
	logic signed [41:0]  r_s4;
	logic signed [31:0]  r_s5;
	logic [61:0]         sq_s5;

	// square root stages
	logic                sq_vld_s  [0:NS];
	logic                sq_kill_s [0:NS];
	logic signed [17:0]  sq_t_s    [0:NS];
	logic signed [31:0]  sq_r_s    [0:NS];
	logic [60:0]         sq_v_s    [0:NS];
	logic [61:0]         sq_res_s  [0:NS];
	logic [60:0]         sq_v_n    [0:NS-1];
	logic [61:0]         sq_res_n  [0:NS-1];

	// vectoring CORDIC stages
	logic                vc_vld_s  [1:NC];
	logic                vc_kill_s [1:NC];
	logic signed [17:0]  vc_t_s    [1:NC];
	logic signed [33:0]  vc_x_s    [1:NC];
	logic signed [33:0]  vc_y_s    [1:NC];
	logic signed [33:0]  vc_z_s    [1:NC];
	logic                vc_vld_i  [0:NC-1];
	logic                vc_kill_i [0:NC-1];
	logic signed [17:0]  vc_t_i    [0:NC-1];
	logic signed [33:0]  vc_x_i    [0:NC-1];
	logic signed [33:0]  vc_y_i    [0:NC-1];
	logic signed [33:0]  vc_z_i    [0:NC-1];
	logic signed [33:0]  vc_x_n    [0:NC-1];
	logic signed [33:0]  vc_y_n    [0:NC-1];
	logic signed [33:0]  vc_z_n    [0:NC-1];

	// conversion stages
	logic                vld_s7, kill_s7, vld_s8, kill_s8;
	logic signed [34:0]  sum_s7;
	logic signed [63:0]  prod_s8;
	logic                done_q;
	logic signed [23:0]  aim_q;
	logic                unr_q;

	logic                accept;
	logic signed [17:0]  t_clamp;
	logic signed [63:0]  deg_rnd;
	logic signed [63:0]  deg_sh;
	logic signed [41:0]  r_neg;
	logic [30:0]         mag;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// elevation clamp
	always_comb begin
		if (sight_elevation > paa_pkg::ELEV_LIMIT) begin
			t_clamp = paa_pkg::ELEV_LIMIT;
		end else if (sight_elevation < -paa_pkg::ELEV_LIMIT) begin
			t_clamp = -paa_pkg::ELEV_LIMIT;
		end else begin
			t_clamp = sight_elevation;
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (range_dist == 24'd0) || (muzzle_speed == 20'd0);
		t_s1    <= t_clamp;
		p_s1    <= {24'd0, paa_pkg::G_Q16} * {20'd0, range_dist};
		dd_s1   <= {20'd0, muzzle_speed} * {20'd0, muzzle_speed};
	end

	// divider step for each stage, sin/cos rotation step for the first NC stages
	always_comb begin
		logic [56:0]        r2;
		logic               ge;
		logic signed [32:0] xs, ys, at;
		for (int j = 0; j < ND; j++) begin
			r2 = {dv_rem_s[j][55:0], 1'b0};
			ge = r2 >= {1'b0, dv_den_s[j]};
			dv_rem_n[j] = ge ? r2 - {1'b0, dv_den_s[j]} : r2;
			dv_quo_n[j] = {dv_quo_s[j][36:0], ge};
			if (j < NC) begin
				xs = cs_x_s[j] >>> j;
				ys = cs_y_s[j] >>> j;
				at = $signed({3'b000, paa_pkg::atan_q30(5'(j))});
				if (cs_z_s[j] >= 0) begin
					cs_x_n[j] = cs_x_s[j] - ys;
					cs_y_n[j] = cs_y_s[j] + xs;
					cs_z_n[j] = cs_z_s[j] - at;
				end else begin
					cs_x_n[j] = cs_x_s[j] + ys;
					cs_y_n[j] = cs_y_s[j] - xs;
					cs_z_n[j] = cs_z_s[j] + at;
				end
			end else begin
				cs_x_n[j] = cs_x_s[j];
				cs_y_n[j] = cs_y_s[j];
				cs_z_n[j] = cs_z_s[j];
			end
		end
	end

	// divider valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= ND; j++) begin
				dv_vld_s[j] <= 1'b0;
			end
		end else begin
			dv_vld_s[0] <= vld_s1;
			for (int j = 0; j < ND; j++) begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end
	end

	// divider and CORDIC payload: zero and quotient overflow checks on entry
	always_ff @(posedge clk) begin
		dv_kill_s[0] <= zero_s1 || ({12'd0, p_s1} >= {dd_s1, 16'd0});
		dv_t_s[0]    <= t_s1;
		dv_rem_s[0]  <= {13'd0, p_s1};
		dv_den_s[0]  <= {dd_s1, 16'd0};
		dv_quo_s[0]  <= 38'd0;
		cs_x_s[0]    <= paa_pkg::CORDIC_GAIN_Q30;
		cs_y_s[0]    <= 33'sd0;
		cs_z_s[0]    <= $signed({t_s1[17], t_s1, 14'd0});
		for (int j = 0; j < ND; j++) begin
			dv_kill_s[j+1] <= dv_kill_s[j];
			dv_t_s[j+1]    <= dv_t_s[j];
			dv_rem_s[j+1]  <= dv_rem_n[j];
			dv_den_s[j+1]  <= dv_den_s[j];
			dv_quo_s[j+1]  <= dv_quo_n[j];
			cs_x_s[j+1]    <= cs_x_n[j];
			cs_y_s[j+1]    <= cs_y_n[j];
			cs_z_s[j+1]    <= cs_z_n[j];
		end
	end

	// argument magnitude for the square root
	always_comb begin
		r_neg = -r_s4;
		mag   = r_s4[41] ? r_neg[30:0] : r_s4[30:0];
	end

	// quotient times cosine, argument sum and range check, squaring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= dv_vld_s[ND];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [30:0]        c;
		logic [39:0]        a;
		logic signed [41:0] r;
		c = cs_x_s[ND][32] ? 31'd0 : cs_x_s[ND][30:0];
		kill_s3    <= dv_kill_s[ND];
		t_s3       <= dv_t_s[ND];
		sin_s3     <= cs_y_s[ND];
		prod_hi_s3 <= {31'd0, dv_quo_s[ND][37:30]} * {8'd0, c};
		prod_lo_s3 <= {31'd0, dv_quo_s[ND][29:0]} * {30'd0, c};

		a = {1'b0, prod_hi_s3} + {9'd0, prod_lo_s3[60:30]};
		r = $signed({2'b00, a}) + {{9{sin_s3[32]}}, sin_s3};
		kill_s4 <= kill_s3 || (r > paa_pkg::ONE_Q30) || (r < -paa_pkg::ONE_Q30);
		t_s4    <= t_s3;
		r_s4    <= r;

		kill_s5 <= kill_s4;
		t_s5    <= t_s4;
		r_s5    <= r_s4[31:0];
		sq_s5   <= {31'd0, mag} * {31'd0, mag};
	end

	// square root steps, one result bit each
	always_comb begin
		logic [61:0] bitv, tr;
		logic        ge;
		for (int k = 0; k < NS; k++) begin
			bitv = 62'd1 << (60 - 2 * k);
			tr   = sq_res_s[k] + bitv;
			ge   = {1'b0, sq_v_s[k]} >= tr;
			if (ge) begin
				sq_v_n[k]   = sq_v_s[k] - tr[60:0];
				sq_res_n[k] = (sq_res_s[k] >> 1) + bitv;
			end else begin
				sq_v_n[k]   = sq_v_s[k];
				sq_res_n[k] = sq_res_s[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++) begin
				sq_vld_s[k] <= 1'b0;
			end
		end else begin
			sq_vld_s[0] <= vld_s5;
			for (int k = 0; k < NS; k++) begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [61:0] v0;
		v0 = paa_pkg::ONE_Q60 - sq_s5;
		sq_kill_s[0] <= kill_s5;
		sq_t_s[0]    <= t_s5;
		sq_r_s[0]    <= r_s5;
		sq_v_s[0]    <= v0[60:0];
		sq_res_s[0]  <= 62'd0;
		for (int k = 0; k < NS; k++) begin
			sq_kill_s[k+1] <= sq_kill_s[k];
			sq_t_s[k+1]    <= sq_t_s[k];
			sq_r_s[k+1]    <= sq_r_s[k];
			sq_v_s[k+1]    <= sq_v_n[k];
			sq_res_s[k+1]  <= sq_res_n[k];
		end
	end

	// vectoring CORDIC: stage inputs, first stage fed by the root
	always_comb begin
		vc_vld_i[0]  = sq_vld_s[NS];
		vc_kill_i[0] = sq_kill_s[NS];
		vc_t_i[0]    = sq_t_s[NS];
		vc_x_i[0]    = $signed({3'b000, sq_res_s[NS][30:0]});
		vc_y_i[0]    = {{2{sq_r_s[NS][31]}}, sq_r_s[NS]};
		vc_z_i[0]    = 34'sd0;
		for (int i = 1; i < NC; i++) begin
			vc_vld_i[i]  = vc_vld_s[i];
			vc_kill_i[i] = vc_kill_s[i];
			vc_t_i[i]    = vc_t_s[i];
			vc_x_i[i]    = vc_x_s[i];
			vc_y_i[i]    = vc_y_s[i];
			vc_z_i[i]    = vc_z_s[i];
		end
	end

	// vectoring steps drive y towards zero
	always_comb begin
		logic signed [33:0] xs, ys, at;
		for (int i = 0; i < NC; i++) begin
			xs = vc_x_i[i] >>> i;
			ys = vc_y_i[i] >>> i;
			at = $signed({4'b0000, paa_pkg::atan_q30(5'(i))});
			if (vc_y_i[i] > 0) begin
				vc_x_n[i] = vc_x_i[i] + ys;
				vc_y_n[i] = vc_y_i[i] - xs;
				vc_z_n[i] = vc_z_i[i] + at;
			end else if (vc_y_i[i] < 0) begin
				vc_x_n[i] = vc_x_i[i] - ys;
				vc_y_n[i] = vc_y_i[i] + xs;
				vc_z_n[i] = vc_z_i[i] - at;
			end else begin
				vc_x_n[i] = vc_x_i[i];
				vc_y_n[i] = vc_y_i[i];
				vc_z_n[i] = vc_z_i[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NC; i++) begin
				vc_vld_s[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < NC; i++) begin
				vc_vld_s[i+1] <= vc_vld_i[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NC; i++) begin
			vc_kill_s[i+1] <= vc_kill_i[i];
			vc_t_s[i+1]    <= vc_t_i[i];
			vc_x_s[i+1]    <= vc_x_n[i];
			vc_y_s[i+1]    <= vc_y_n[i];
			vc_z_s[i+1]    <= vc_z_n[i];
		end
	end

	// degree conversion, rounding and clamp
	always_comb begin
		deg_rnd = prod_s8 + paa_pkg::ROUND_HALF;
		deg_sh  = deg_rnd >>> 38;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s7 <= vc_vld_s[NC];
			vld_s8 <= vld_s7;
			done_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		kill_s7 <= vc_kill_s[NC];
		sum_s7  <= {vc_z_s[NC][33], vc_z_s[NC]}
			+ $signed({{3{vc_t_s[NC][17]}}, vc_t_s[NC], 14'd0});
		kill_s8 <= kill_s7;
		prod_s8 <= $signed({{29{sum_s7[34]}}, sum_s7})
			* $signed({34'd0, paa_pkg::DEG_PER_2RAD_Q24});
		unr_q   <= kill_s8;
		if (kill_s8) begin
			aim_q <= 24'sd0;
		end else if (deg_sh > paa_pkg::OUT_MAX) begin
			aim_q <= paa_pkg::OUT_MAX[23:0];
		end else if (deg_sh < -paa_pkg::OUT_MAX) begin
			aim_q <= -paa_pkg::OUT_MAX[23:0];
		end else begin
			aim_q <= deg_sh[23:0];
		end
	end

	// result beat
	assign done        = done_q;
	assign aim_degrees = aim_q;
	assign unreachable = unr_q;

endmodule

`default_nettype wire

/* bench/tb_projectile_aim_angle.sv */
// Testbench for projectile_aim_angle: directed and random beats checked against
// a bit-exact fixed-point predictor of the aim-angle pipeline.
// Depends on paa_pkg and rtl/core/projectile_aim_angle.sv.
`timescale 1ns / 100ps

module tb_projectile_aim_angle;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 130;

	typedef struct packed {
		logic signed [23:0] degrees;
		logic               unreach;
	} aim_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [23:0]        range_dist;
	logic [19:0]        muzzle_speed;
	logic signed [17:0] sight_elevation;
	logic               done;
	logic signed [23:0] aim_degrees;
	logic               unreachable;

	aim_t   pending_aims[$];
	int     error_count;
	int     idle_cycles;
	int     burst_left;
	longint atan_lut[paa_pkg::CORDIC_STEPS];

	projectile_aim_angle uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.range_dist      (range_dist),
		.muzzle_speed    (muzzle_speed),
		.sight_elevation (sight_elevation),
		.done            (done),
		.aim_degrees     (aim_degrees),
		.unreachable     (unreachable)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// arctangent of 2^-i, truncated Q30
	initial begin
		atan_lut = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// aim angle for one beat
	function automatic aim_t predict_aim(input logic [23:0] rng, input logic [19:0] spd,
			input logic signed [17:0] elev);
		aim_t            res;
		longint          t, x, y, z, xs, ys, sn, cs, a, r, w, asn, sum, deg;
		longint unsigned p, d, qi, rm, frac, mag;
		res.degrees = '0;
		res.unreach = 1'b1;
		t = elev;
		if (t > 102000)
			t = 102000;
		if (t < -102000)
			t = -102000;
		if (rng == 0 || spd == 0)
			return res;
		// sin and cos by rotation
		x = 652032874;
		y = 0;
		z = t * 16384;
		for (int i = 0; i < paa_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - atan_lut[i];
			end else begin
				x = x + ys; y = y - xs; z = z + atan_lut[i];
			end
		end
		sn = y;
		cs = (x < 0) ? 0 : x;
		// g*R/V^2 as Q30
		p = 64'd642712 * rng;
		d = longint'(spd) * longint'(spd) * 256;
		qi = p / d;
		if (qi >= 256)
			return res;
		rm = p % d;
		frac = 0;
		for (int i = 0; i < 30; i++) begin
			rm = rm << 1;
			frac = frac << 1;
			if (rm >= d) begin
				rm = rm - d;
				frac = frac | 1;
			end
		end
		a = longint'(qi * longint'(cs) + ((frac * longint'(cs)) >> 30));
		r = a + sn;
		if (r > 64'sd1073741824 || r < -64'sd1073741824)
			return res;
		// arcsine by vectoring
		mag = (r < 0) ? -r : r;
		w = int_sqrt((64'd1 << 60) - mag * mag);
		y = r;
		x = w;
		asn = 0;
		for (int i = 0; i < paa_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; asn = asn + atan_lut[i];
			end else if (y < 0) begin
				x = x - ys; y = y + xs; asn = asn - atan_lut[i];
			end
		end
		sum = asn + t * 16384;
		deg = (sum * 480631835 + (64'sd1 <<< 37)) >>> 38;
		if (deg > 5898240)
			deg = 5898240;
		if (deg < -5898240)
			deg = -5898240;
		res.degrees = deg[23:0];
		res.unreach = 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// send one beat, respecting the burst pattern
	task automatic send_beat(input logic [23:0] rng, input logic [19:0] spd,
			input logic signed [17:0] elev);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 30);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		range_dist <= rng;
		muzzle_speed <= spd;
		sight_elevation <= elev;
		do
			@(posedge clk);
		while (busy);
		pending_aims.push_back(predict_aim(rng, spd, elev));
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_aims.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_beat(24'd0, 20'd5000, 18'sd0);
		send_beat(24'd5000, 20'd0, 18'sd0);
		send_beat(24'd0, 20'd0, 18'sd0);
		send_beat(24'hFFFFFF, 20'hFFFFF, 18'sd0);
		send_beat(24'hFFFFFF, 20'hFFFFF, 18'sd102000);
		send_beat(24'hFFFFFF, 20'hFFFFF, -18'sd102000);
		send_beat(24'd256, 20'hFFFFF, 18'sd131071);
		send_beat(24'd256, 20'hFFFFF, -18'sd131072);
		send_beat(24'd25600, 20'd51200, 18'sd102001);
		send_beat(24'hFFFFFF, 20'd1, 18'sd0);
		send_beat(24'hFFFFFF, 20'd256, 18'sd30000);
		send_beat(24'd256000, 20'd12800, 18'sd0);
		send_beat(24'd256000, 20'd25600, 18'sd20000);
		send_beat(24'd256000, 20'd25600, -18'sd20000);
		send_beat(24'd1, 20'd1, 18'sd0);
		send_beat(24'd1, 20'hFFFFF, 18'sd1);
		send_beat(24'd1, 20'hFFFFF, -18'sd1);
		send_beat(24'd2560, 20'd51200, 18'sd60000);
		send_beat(24'd2560, 20'd51200, -18'sd90000);
		send_beat(24'h800000, 20'h80000, 18'sd51472);
	endtask

	// well-formed beats: range chosen from the speed so the target is usually in reach
	task automatic test_random_reachable(input int n);
		logic [19:0]     spd;
		longint unsigned top;
		for (int i = 0; i < n; i++) begin
			spd = $urandom_range(1, 20'hFFFFF);
			top = longint'(spd) * longint'(spd) / 2400;
			if (top > 24'hFFFFFF)
				top = 24'hFFFFFF;
			send_beat(24'($urandom_range(0, int'(top))), spd,
				18'($signed($urandom_range(0, 204000)) - 102000));
		end
	endtask

	// raw random fields over the whole port range
	task automatic test_random_noise(input int n);
		for (int i = 0; i < n; i++)
			send_beat(24'($urandom), 20'($urandom), 18'($urandom));
	endtask

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		aim_t want;
		if (arst_n && done) begin
			if (pending_aims.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pending_aims.pop_front();
				if (unreachable !== want.unreach)
					report_mismatch($sformatf("unreachable %b want %b",
						unreachable, want.unreach));
				if (aim_degrees !== want.degrees)
					report_mismatch($sformatf("aim_degrees %0d want %0d",
						aim_degrees, want.degrees));
			end
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if (!arst_n || done === 1'b1 || (start && busy === 1'b0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		range_dist = '0;
		muzzle_speed = '0;
		sight_elevation = '0;
		error_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_all_results();
		test_random_reachable(500);
		test_random_noise(150);
		wait_all_results();
		test_random_reachable(300);
		test_random_noise(130);
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_aims.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/paa_pkg.sv
rtl/core/projectile_aim_angle.sv
bench/tb_projectile_aim_angle.sv
